// File: design/aada_pkg.sv
// Shared widths and the accelerometer sample decode for the average decimator.
package aada_pkg;

  localparam int AXES = 3;
  localparam int BYTE_W = 8;
  localparam int MEAN_W = 12;
  localparam int SUM_W = 17;
  localparam int MAG_W = 16;
  localparam int CNT_W = 5;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = MAG_W + RECIP_W;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic signed [MEAN_W-1:0] mean_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [PROD_W-1:0] prod_t;

  // The left-justified 16-bit word divided by 16, rounded toward zero.
  function automatic mean_t pair_to_count(input byte_t hi, input byte_t lo);
    logic [2*BYTE_W-1:0] raw;
    mean_t floor_q;
    begin
      raw = {hi, lo};
      floor_q = mean_t'(raw[2*BYTE_W-1:4]);
      if (raw[2*BYTE_W-1] && (raw[3:0] != 4'd0)) begin
        pair_to_count = floor_q + mean_t'(1);
      end else begin
        pair_to_count = floor_q;
      end
    end
  endfunction

endpackage

// File: design/accel_decode_average_decimator_top.sv
// Accelerometer read decoder with a boxcar average over DECIMATION_FACTOR reads.
//
// The input channel takes one word per accelerometer read: a high and a low
// byte for each axis. A word is taken at a rising edge where in_valid is high
// and in_stall is low. Each read is decoded to a signed count and added into
// the per-axis sums. The read that completes a window hands the sums to a
// three-stage output path and clears the sums and the read count.
// The output channel presents one word of three means per window. The word is
// taken at an edge where out_valid is high and out_stall is low.
// Throughput is one read per cycle while in_stall is low.
// Stages are: window capture, magnitude times reciprocal of the factor, then
// shift and sign restore into the output register.
// When the receiver stalls, the output path fills; in_stall rises only when
// the window capture stage cannot advance.
// A synchronous reset clears the sums, the read count and all valid flags.
module accel_decode_average_decimator_top #(
  parameter int DECIMATION_FACTOR = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  aada_pkg::byte_t x_high_byte,
  input  aada_pkg::byte_t x_low_byte,
  input  aada_pkg::byte_t y_high_byte,
  input  aada_pkg::byte_t y_low_byte,
  input  aada_pkg::byte_t z_high_byte,
  input  aada_pkg::byte_t z_low_byte,
  output logic out_valid,
  input  logic out_stall,
  output aada_pkg::mean_t mean_x,
  output aada_pkg::mean_t mean_y,
  output aada_pkg::mean_t mean_z
);
  import aada_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + DECIMATION_FACTOR - 1) / DECIMATION_FACTOR);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(DECIMATION_FACTOR - 1);

  byte_t hi_byte [AXES];
  byte_t lo_byte [AXES];
  sum_t sum [AXES];
  sum_t sum_next [AXES];
  sum_t win [AXES];
  prod_t prod [AXES];
  logic neg [AXES];
  mean_t mean [AXES];
  logic [CNT_W-1:0] sample_count;
  logic s1_valid;
  logic s2_valid;
  logic out_ready;
  logic s2_ready;
  logic s1_ready;
  logic in_acc;
  logic last;

  assign hi_byte[0] = x_high_byte;
  assign lo_byte[0] = x_low_byte;
  assign hi_byte[1] = y_high_byte;
  assign lo_byte[1] = y_low_byte;
  assign hi_byte[2] = z_high_byte;
  assign lo_byte[2] = z_low_byte;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign in_acc = in_valid && s1_ready;
  assign last = (sample_count == LAST_COUNT);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_next[a] = sum[a] + SUM_W'(pair_to_count(hi_byte[a], lo_byte[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= '0;
      end
    end else begin
      if (in_acc) begin
        if (last) begin
          sample_count <= '0;
          for (int a = 0; a < AXES; a++) begin
            sum[a] <= '0;
            win[a] <= sum_next[a];
          end
        end else begin
          sample_count <= sample_count + CNT_W'(1);
          for (int a = 0; a < AXES; a++) begin
            sum[a] <= sum_next[a];
          end
        end
      end
      if (in_acc && last) begin
        s1_valid <= 1'b1;
      end else if (s2_ready) begin
        s1_valid <= 1'b0;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
        for (int a = 0; a < AXES; a++) begin
          neg[a] <= win[a][SUM_W-1];
          prod[a] <= PROD_W'(mag_t'(win[a][SUM_W-1] ? -win[a] : win[a])) *
                     PROD_W'(RECIP);
        end
      end
      if (out_ready) begin
        out_valid <= s2_valid;
        for (int a = 0; a < AXES; a++) begin
          mean[a] <= neg[a] ? -mean_t'(prod[a][RECIP_SHIFT +: MEAN_W])
                            : mean_t'(prod[a][RECIP_SHIFT +: MEAN_W]);
        end
      end
    end
  end

  assign mean_x = mean[0];
  assign mean_y = mean[1];
  assign mean_z = mean[2];

endmodule

// File: dv/tb_accel_decode_average_decimator_top.sv
// Self-checking testbench for the accelerometer decode and boxcar average decimator.
module tb_accel_decode_average_decimator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aada_pkg::*;

  localparam int FACTOR = 10;
  localparam int RANDOM_READS = 1600;
  localparam int QUIET_READS = 200;
  localparam int HOLD_AT_READ = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    mean_t x;
    mean_t y;
    mean_t z;
  } mean_word_t;

  class mean_scoreboard;
    int factor;
    int sum_x;
    int sum_y;
    int sum_z;
    int reads_in_window;
    int errors;
    mean_word_t expected_means[$];

    function new(int factor_i);
      factor = factor_i;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      reads_in_window = 0;
      errors = 0;
    endfunction

    static function int axis_count(byte_t hi, byte_t lo);
      logic signed [15:0] raw;
      int count;
      raw = {hi, lo};
      count = raw;
      return count / 16;
    endfunction

    function void note_read(byte_t xh, byte_t xl, byte_t yh, byte_t yl, byte_t zh, byte_t zl);
      mean_word_t m;
      sum_x += axis_count(xh, xl);
      sum_y += axis_count(yh, yl);
      sum_z += axis_count(zh, zl);
      reads_in_window++;
      if (reads_in_window >= factor) begin
        m.x = mean_t'(sum_x / factor);
        m.y = mean_t'(sum_y / factor);
        m.z = mean_t'(sum_z / factor);
        expected_means.push_back(m);
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        reads_in_window = 0;
      end
    endfunction

    function void check_means(mean_t got_x, mean_t got_y, mean_t got_z);
      mean_word_t m;
      if (expected_means.size() == 0) begin
        $error("Mean word arrived with no window closed: %0d %0d %0d", got_x, got_y, got_z);
        errors++;
        return;
      end
      m = expected_means.pop_front();
      if (got_x !== m.x) begin
        $error("mean_x: expected %0d, got %0d", m.x, got_x);
        errors++;
      end
      if (got_y !== m.y) begin
        $error("mean_y: expected %0d, got %0d", m.y, got_y);
        errors++;
      end
      if (got_z !== m.z) begin
        $error("mean_z: expected %0d, got %0d", m.z, got_z);
        errors++;
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  byte_t x_high_byte = '0;
  byte_t x_low_byte = '0;
  byte_t y_high_byte = '0;
  byte_t y_low_byte = '0;
  byte_t z_high_byte = '0;
  byte_t z_low_byte = '0;
  logic in_stall;
  logic out_valid;
  mean_t mean_x;
  mean_t mean_y;
  mean_t mean_z;

  mean_scoreboard sb;
  int cycle_count = 0;
  int long_hold = 0;
  bit quiet = 1'b0;

  accel_decode_average_decimator_top #(
    .DECIMATION_FACTOR(FACTOR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .x_high_byte(x_high_byte),
    .x_low_byte(x_low_byte),
    .y_high_byte(y_high_byte),
    .y_low_byte(y_low_byte),
    .z_high_byte(z_high_byte),
    .z_low_byte(z_low_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mean_x(mean_x),
    .mean_y(mean_y),
    .mean_z(mean_z)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_read(input logic [15:0] wx, input logic [15:0] wy, input logic [15:0] wz);
    x_high_byte <= wx[15:8];
    x_low_byte <= wx[7:0];
    y_high_byte <= wy[15:8];
    y_low_byte <= wy[7:0];
    z_high_byte <= wz[15:8];
    z_low_byte <= wz[7:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_read(wx[15:8], wx[7:0], wy[15:8], wy[7:0], wz[15:8], wz[7:0]);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word(input int mode);
    logic [15:0] w;
    case (mode)
      1: w = {12'h7FF, 4'($urandom_range(0, 15))};
      2: w = {12'h800, 4'($urandom_range(0, 15))};
      3: w = {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, 8'($urandom_range(0, 255))};
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  initial begin
    int mode_x;
    int mode_y;
    int mode_z;
    bit gaps_on;
    sb = new(FACTOR);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < FACTOR; i++) begin
      send_read(16'h7FFF, 16'h8000, (i % 2 != 0) ? 16'hFFF1 : 16'hFFFF);
    end
    for (int i = 0; i < FACTOR; i++) begin
      send_read((i % 2 != 0) ? 16'h800F : 16'h8000, (i % 2 != 0) ? 16'h7FF0 : 16'h0010,
                (i < FACTOR / 2) ? 16'hFFF0 : 16'h0000);
    end

    mode_x = 0;
    mode_y = 0;
    mode_z = 0;
    gaps_on = 1'b0;
    for (int n = 0; n < RANDOM_READS; n++) begin
      if (n % FACTOR == 0) begin
        mode_x = $urandom_range(0, 4);
        mode_y = $urandom_range(0, 4);
        mode_z = $urandom_range(0, 4);
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (n == HOLD_AT_READ) begin
        long_hold = HOLD_CYCLES;
      end
      if (n >= RANDOM_READS - QUIET_READS) begin
        quiet = 1'b1;
      end
      send_read(pick_word(mode_x), pick_word(mode_y), pick_word(mode_z));
      if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
        pause_sender($urandom_range(1, 11));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall_left;
    int stretch_left;
    bit stalls_on;
    stall_left = 0;
    stretch_left = 0;
    stalls_on = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_means(mean_x, mean_y, mean_z);
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(50, 200);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      stretch_left--;
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
